>>> rtl/rcpi_pkg.sv
// ============================================================================
// rcpi_pkg: shared types and constants for the ray/polyhedron clipper
// Holds the plane record, the divider cell record, opcodes, pick codes,
// register indexes and the controller state type.
// ============================================================================
package rcpi_pkg;

    // Fixed widths that follow from the Q16.16 operands
    localparam int QBITS = 32;          // Q16.16 word
    localparam int DW    = 49;          // magnitude of numerator / denominator
    localparam int QW    = 33;          // quotient bits produced by the divider
    localparam int SW    = 50;          // signed dot-product sum width

    localparam logic       OP_LOAD = 1'b0;
    localparam logic       OP_RAY  = 1'b1;

    localparam logic [1:0] PICK_NONE  = 2'd0;
    localparam logic [1:0] PICK_ENTER = 2'd1;
    localparam logic [1:0] PICK_EXIT  = 2'd2;

    localparam logic       REG_ACTIVE_PLANES = 1'b0;

    localparam logic signed [QBITS-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QBITS-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    // One bounding plane: n.p = d
    typedef struct packed {
        logic signed [QBITS-1:0] nx;
        logic signed [QBITS-1:0] ny;
        logic signed [QBITS-1:0] nz;
        logic signed [QBITS-1:0] d;
    } plane_t;

    // Record handed from one divider cell to the next
    typedef struct packed {
        logic                    live;
        logic                    last;
        logic                    den_neg;
        logic                    neg;
        logic                    ov;
        logic [DW-1:0]           rem;
        logic [QW-1:0]           lo;
        logic [QW-1:0]           q;
        logic [DW-1:0]           ud;
        logic signed [QBITS-1:0] nx;
        logic signed [QBITS-1:0] ny;
        logic signed [QBITS-1:0] nz;
    } div_t;

endpackage

>>> rtl/ray_convex_polyhedron_intersect.sv
// ============================================================================
// ray_convex_polyhedron_intersect: ray against a convex set of planes
// Clips a ray against a table of bounding planes and reports the picked hit.
// ============================================================================
// Once a ray transaction is accepted, the plane ring rotates once, handing
// one plane per cycle into the dot-product stages, and each plane then
// passes a chain of 33 divider cells, one quotient bit per cell, before it
// is folded into the entering/exiting limits. The block takes the next
// transaction once the result has moved to the output register. Plane
// storage has no reset; a ray must only use loaded slots.
module ray_convex_polyhedron_intersect #(
    parameter int MAX_PLANES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_plane_slot,
    input  logic signed [31:0] s_vec_x,
    input  logic signed [31:0] s_vec_y,
    input  logic signed [31:0] s_vec_z,
    input  logic signed [31:0] s_scalar,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit_valid,
    output logic [1:0]         m_pick,
    output logic signed [31:0] m_hit_t,
    output logic signed [31:0] m_hit_nx,
    output logic signed [31:0] m_hit_ny,
    output logic signed [31:0] m_hit_nz,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IDXW  = $clog2(MAX_PLANES);
    localparam int CW    = ($clog2(MAX_PLANES + 1) > 5) ? $clog2(MAX_PLANES + 1) : 5;
    localparam int DW    = rcpi_pkg::DW;
    localparam int QW    = rcpi_pkg::QW;
    localparam int SW    = rcpi_pkg::SW;
    localparam int NCELL = QW;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [4:0] active_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rcpi_pkg::REG_ACTIVE_PLANES) ? {27'd0, active_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 5'd0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == rcpi_pkg::REG_ACTIVE_PLANES) begin
            active_reg <= pwdata[4:0];
        end
    end

    // ------------------------------------------------------------------
    // Controller
    // ------------------------------------------------------------------
    rcpi_pkg::state_t state_reg, state_next;
    logic             issuing_reg, issuing_next;
    logic [IDXW-1:0]  idx_reg, idx_next;
    logic             s_take, ray_take, load_take;
    logic             out_free;
    logic             e_last_seen;

    assign s_ready   = (state_reg == rcpi_pkg::ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign ray_take  = s_take && (s_opcode == rcpi_pkg::OP_RAY);
    assign load_take = s_take && (s_opcode == rcpi_pkg::OP_LOAD);
    assign out_free  = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rcpi_pkg::ST_IDLE;
            issuing_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            issuing_reg <= issuing_next;
            idx_reg     <= idx_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        issuing_next = issuing_reg;
        idx_next     = idx_reg;
        unique case (state_reg)
            rcpi_pkg::ST_IDLE: begin
                if (ray_take) begin
                    state_next   = rcpi_pkg::ST_RUN;
                    issuing_next = 1'b1;
                    idx_next     = '0;
                end
            end
            rcpi_pkg::ST_RUN: begin
                if (issuing_reg) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDXW'(MAX_PLANES - 1)) begin
                        issuing_next = 1'b0;
                    end
                end
                if (e_last_seen) begin
                    state_next = rcpi_pkg::ST_FIN;
                end
            end
            rcpi_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = rcpi_pkg::ST_IDLE;
                end
            end
            default: state_next = rcpi_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Ray registers, captured when a ray transaction is accepted
    // ------------------------------------------------------------------
    logic signed [31:0] dir_x_reg, dir_y_reg, dir_z_reg;
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic signed [31:0] tmin_reg;

    always_ff @(posedge aclk) begin
        if (ray_take) begin
            dir_x_reg <= s_vec_x;
            dir_y_reg <= s_vec_y;
            dir_z_reg <= s_vec_z;
            org_x_reg <= s_origin_x;
            org_y_reg <= s_origin_y;
            org_z_reg <= s_origin_z;
            tmin_reg  <= s_scalar;
        end
    end

    // ------------------------------------------------------------------
    // Plane ring: rotates once per ray, cell 0 is the head
    // ------------------------------------------------------------------
    rcpi_pkg::plane_t ring_out [MAX_PLANES];
    rcpi_pkg::plane_t load_plane;

    assign load_plane = '{nx: s_vec_x, ny: s_vec_y, nz: s_vec_z, d: s_scalar};

    for (genvar i = 0; i < MAX_PLANES; i++) begin : g_ring
        rcpi_plane_cell u_cell (
            .aclk       (aclk),
            .load_en    (load_take && (32'(s_plane_slot) == i)),
            .load_plane (load_plane),
            .shift_en   (issuing_reg),
            .shift_in   (ring_out[(i + 1) % MAX_PLANES]),
            .cell_out   (ring_out[i])
        );
    end

    // ------------------------------------------------------------------
    // Stage A: six products of the head plane with direction and origin
    // ------------------------------------------------------------------
    logic                    a_live_reg, a_last_reg;
    logic signed [63:0]      a_pd_reg [3];
    logic signed [63:0]      a_po_reg [3];
    rcpi_pkg::plane_t        a_plane_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_live_reg <= 1'b0;
            a_last_reg <= 1'b0;
        end else begin
            a_live_reg <= issuing_reg && (CW'(idx_reg) < CW'(active_reg));
            a_last_reg <= issuing_reg && (idx_reg == IDXW'(MAX_PLANES - 1));
        end
    end

    always_ff @(posedge aclk) begin
        a_pd_reg[0] <= 64'(ring_out[0].nx) * 64'(dir_x_reg);
        a_pd_reg[1] <= 64'(ring_out[0].ny) * 64'(dir_y_reg);
        a_pd_reg[2] <= 64'(ring_out[0].nz) * 64'(dir_z_reg);
        a_po_reg[0] <= 64'(ring_out[0].nx) * 64'(org_x_reg);
        a_po_reg[1] <= 64'(ring_out[0].ny) * 64'(org_y_reg);
        a_po_reg[2] <= 64'(ring_out[0].nz) * 64'(org_z_reg);
        a_plane_reg <= ring_out[0];
    end

    // ------------------------------------------------------------------
    // Stage B: floored products summed into denominator and numerator
    // ------------------------------------------------------------------
    logic                 b_live_reg, b_last_reg;
    logic signed [SW-1:0] b_den_reg, b_num_reg;
    rcpi_pkg::plane_t     b_plane_reg;
    logic signed [SW-1:0] den_sum, org_sum;

    always_comb begin
        den_sum = SW'(a_pd_reg[0] >>> 16) + SW'(a_pd_reg[1] >>> 16) + SW'(a_pd_reg[2] >>> 16);
        org_sum = SW'(a_po_reg[0] >>> 16) + SW'(a_po_reg[1] >>> 16) + SW'(a_po_reg[2] >>> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_live_reg <= 1'b0;
            b_last_reg <= 1'b0;
        end else begin
            b_live_reg <= a_live_reg;
            b_last_reg <= a_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        b_den_reg   <= den_sum;
        b_num_reg   <= SW'(a_plane_reg.d) - org_sum;
        b_plane_reg <= a_plane_reg;
    end

    // ------------------------------------------------------------------
    // Stage C: magnitudes and signs; a parallel plane is dropped here
    // ------------------------------------------------------------------
    logic             c_live_reg, c_last_reg;
    logic             c_neg_reg, c_den_neg_reg;
    logic [DW-1:0]    c_un_reg, c_ud_reg;
    rcpi_pkg::plane_t c_plane_reg;
    logic [SW-1:0]    num_abs, den_abs;

    always_comb begin
        num_abs = b_num_reg[SW-1] ? SW'(-b_num_reg) : SW'(b_num_reg);
        den_abs = b_den_reg[SW-1] ? SW'(-b_den_reg) : SW'(b_den_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_live_reg <= 1'b0;
            c_last_reg <= 1'b0;
        end else begin
            c_live_reg <= b_live_reg && (b_den_reg != '0);
            c_last_reg <= b_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        c_neg_reg     <= b_num_reg[SW-1] ^ b_den_reg[SW-1];
        c_den_neg_reg <= b_den_reg[SW-1];
        c_un_reg      <= num_abs[DW-1:0];
        c_ud_reg      <= den_abs[DW-1:0];
        c_plane_reg   <= b_plane_reg;
    end

    // ------------------------------------------------------------------
    // Stage D: overflow check and divider seed
    // ------------------------------------------------------------------
    rcpi_pkg::div_t d_reg;
    rcpi_pkg::div_t d_next;

    always_comb begin
        d_next         = '0;
        d_next.live    = c_live_reg;
        d_next.last    = c_last_reg;
        d_next.den_neg = c_den_neg_reg;
        d_next.neg     = c_neg_reg;
        d_next.ov      = ({17'd0, c_un_reg} >= {c_ud_reg, 17'd0});
        d_next.rem     = {17'd0, c_un_reg[DW-1:17]};
        d_next.lo      = {c_un_reg[16:0], 16'd0};
        d_next.q       = '0;
        d_next.ud      = c_ud_reg;
        d_next.nx      = c_plane_reg.nx;
        d_next.ny      = c_plane_reg.ny;
        d_next.nz      = c_plane_reg.nz;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.live <= 1'b0;
            d_reg.last <= 1'b0;
        end else begin
            d_reg <= d_next;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain, one quotient bit per cell
    // ------------------------------------------------------------------
    rcpi_pkg::div_t chain [NCELL+1];

    assign chain[0] = d_reg;

    for (genvar k = 0; k < NCELL; k++) begin : g_div
        rcpi_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage E: signed, saturated ray parameter
    // ------------------------------------------------------------------
    rcpi_pkg::div_t     dq;
    logic               e_live_reg, e_last_reg, e_den_neg_reg;
    logic signed [31:0] e_t_reg, e_nx_reg, e_ny_reg, e_nz_reg;
    logic signed [31:0] t_val;

    assign dq = chain[NCELL];

    always_comb begin
        if (dq.neg) begin
            if (dq.ov || dq.q > QW'(33'h0_8000_0000)) begin
                t_val = rcpi_pkg::Q_MIN;
            end else begin
                t_val = 32'(-dq.q[31:0]);
            end
        end else begin
            if (dq.ov || dq.q > QW'(33'h0_7FFF_FFFF)) begin
                t_val = rcpi_pkg::Q_MAX;
            end else begin
                t_val = dq.q[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_live_reg <= 1'b0;
            e_last_reg <= 1'b0;
        end else begin
            e_live_reg <= dq.live;
            e_last_reg <= dq.last;
        end
    end

    always_ff @(posedge aclk) begin
        e_den_neg_reg <= dq.den_neg;
        e_t_reg       <= t_val;
        e_nx_reg      <= dq.nx;
        e_ny_reg      <= dq.ny;
        e_nz_reg      <= dq.nz;
    end

    assign e_last_seen = e_last_reg;

    // ------------------------------------------------------------------
    // Stage F: entering and exiting limits
    // ------------------------------------------------------------------
    logic               have_en_reg, have_ex_reg;
    logic signed [31:0] t_en_reg, t_ex_reg;
    logic signed [31:0] en_x_reg, en_y_reg, en_z_reg;
    logic signed [31:0] ex_x_reg, ex_y_reg, ex_z_reg;
    logic               upd_en, upd_ex;

    assign upd_en = e_live_reg && e_den_neg_reg && (!have_en_reg || e_t_reg > t_en_reg);
    assign upd_ex = e_live_reg && !e_den_neg_reg && (!have_ex_reg || e_t_reg < t_ex_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_en_reg <= 1'b0;
            have_ex_reg <= 1'b0;
        end else if (ray_take) begin
            have_en_reg <= 1'b0;
            have_ex_reg <= 1'b0;
        end else begin
            if (upd_en) begin
                have_en_reg <= 1'b1;
            end
            if (upd_ex) begin
                have_ex_reg <= 1'b1;
            end
        end
    end

    // Normals of an exit limit that was never set read as zero.
    always_ff @(posedge aclk) begin
        if (ray_take) begin
            ex_x_reg <= '0;
            ex_y_reg <= '0;
            ex_z_reg <= '0;
        end else if (upd_ex) begin
            t_ex_reg <= e_t_reg;
            ex_x_reg <= e_nx_reg;
            ex_y_reg <= e_ny_reg;
            ex_z_reg <= e_nz_reg;
        end
        if (upd_en) begin
            t_en_reg <= e_t_reg;
            en_x_reg <= e_nx_reg;
            en_y_reg <= e_ny_reg;
            en_z_reg <= e_nz_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result selection and output register
    // ------------------------------------------------------------------
    logic               res_valid;
    logic [1:0]         res_pick;
    logic signed [31:0] res_t, res_nx, res_ny, res_nz;

    always_comb begin
        res_valid = !(have_en_reg && have_ex_reg) || (t_en_reg < t_ex_reg);
        res_pick  = rcpi_pkg::PICK_NONE;
        res_t     = '0;
        res_nx    = '0;
        res_ny    = '0;
        res_nz    = '0;
        if (res_valid) begin
            priority if (have_en_reg && t_en_reg > tmin_reg) begin
                res_pick = rcpi_pkg::PICK_ENTER;
                res_t    = t_en_reg;
                res_nx   = en_x_reg;
                res_ny   = en_y_reg;
                res_nz   = en_z_reg;
            end else if (!have_ex_reg || t_ex_reg > tmin_reg) begin
                res_pick = rcpi_pkg::PICK_EXIT;
                res_t    = have_ex_reg ? t_ex_reg : rcpi_pkg::Q_MAX;
                res_nx   = ex_x_reg;
                res_ny   = ex_y_reg;
                res_nz   = ex_z_reg;
            end
        end
    end

    logic               m_valid_reg;
    logic               m_hit_valid_reg;
    logic [1:0]         m_pick_reg;
    logic signed [31:0] m_hit_t_reg, m_hit_nx_reg, m_hit_ny_reg, m_hit_nz_reg;
    logic               out_load;

    assign out_load = (state_reg == rcpi_pkg::ST_FIN) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_hit_valid_reg <= res_valid;
            m_pick_reg      <= res_pick;
            m_hit_t_reg     <= res_t;
            m_hit_nx_reg    <= res_nx;
            m_hit_ny_reg    <= res_ny;
            m_hit_nz_reg    <= res_nz;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit_valid = m_hit_valid_reg;
    assign m_pick      = m_pick_reg;
    assign m_hit_t     = m_hit_t_reg;
    assign m_hit_nx    = m_hit_nx_reg;
    assign m_hit_ny    = m_hit_ny_reg;
    assign m_hit_nz    = m_hit_nz_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The ring only rotates while a ray is in flight.
    a_issue_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        issuing_reg |-> (state_reg == rcpi_pkg::ST_RUN))
        else $error("plane ring rotating outside a ray");

    // A finished ray with a free output slot is delivered and the block idles.
    a_fin_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && state_reg == rcpi_pkg::ST_IDLE))
        else $error("finished ray not moved to the output register");

    // A missed polyhedron never reports a pick.
    a_miss_no_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_hit_valid_reg) |-> (m_pick_reg == rcpi_pkg::PICK_NONE))
        else $error("pick reported for an invalid hit");

endmodule

>>> rtl/rcpi_plane_cell.sv
// ============================================================================
// rcpi_plane_cell: one slot of the plane ring
// Holds one plane. It is written by a plane load or takes its neighbor's
// plane when the ring rotates.
// ============================================================================
module rcpi_plane_cell (
    input  logic            aclk,
    input  logic            load_en,
    input  rcpi_pkg::plane_t load_plane,
    input  logic            shift_en,
    input  rcpi_pkg::plane_t shift_in,
    output rcpi_pkg::plane_t cell_out
);

    rcpi_pkg::plane_t plane_reg;
    rcpi_pkg::plane_t plane_next;

    // A load and a rotation never happen in the same cycle.
    always_comb begin
        plane_next = plane_reg;
        if (load_en) begin
            plane_next = load_plane;
        end else if (shift_en) begin
            plane_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        plane_reg <= plane_next;
    end

    assign cell_out = plane_reg;

endmodule

>>> rtl/rcpi_div_cell.sv
// ============================================================================
// rcpi_div_cell: one step of the restoring divider chain
// Produces one quotient bit per cell and passes the partial remainder and
// the plane data on to the next cell.
// ============================================================================
module rcpi_div_cell (
    input  logic          aclk,
    input  logic          aresetn,
    input  rcpi_pkg::div_t cell_in,
    output rcpi_pkg::div_t cell_out
);

    localparam int DW = rcpi_pkg::DW;
    localparam int QW = rcpi_pkg::QW;

    rcpi_pkg::div_t cell_reg;
    rcpi_pkg::div_t cell_next;
    logic [DW:0]    trial;
    logic [DW:0]    diff;
    logic           ge;

    // Shift in the next dividend bit and subtract the divisor if it fits.
    always_comb begin
        trial          = {cell_in.rem, cell_in.lo[QW-1]};
        diff           = trial - {1'b0, cell_in.ud};
        ge             = (trial >= {1'b0, cell_in.ud});
        cell_next      = cell_in;
        cell_next.rem  = ge ? diff[DW-1:0] : trial[DW-1:0];
        cell_next.lo   = {cell_in.lo[QW-2:0], 1'b0};
        cell_next.q    = {cell_in.q[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.live <= 1'b0;
            cell_reg.last <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

>>> dv/ray_convex_polyhedron_intersect_tb.sv
// ============================================================================
// ray_convex_polyhedron_intersect_tb: self-checking bench for the plane clipper
// Sends plane loads and rays with bursty input and a stalling output, and compares
// every result with a directed expectation or an in-bench model of the clipping math.
// ============================================================================
module ray_convex_polyhedron_intersect_tb;

    localparam int NPLANES     = 16;
    localparam int DRAIN_WAIT  = NPLANES + 60;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic               op;
        logic [3:0]         slot;
        logic signed [31:0] vx, vy, vz, sc, ox, oy, oz;
    } item_t;

    typedef struct {
        logic               hv;
        logic [1:0]         pick;
        logic signed [31:0] t, nx, ny, nz;
    } hit_t;

    typedef struct {
        item_t it;
        bit    typed;
        hit_t  res;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = rcpi_pkg::OP_LOAD;
    logic [3:0]         s_plane_slot = '0;
    logic signed [31:0] s_vec_x = '0, s_vec_y = '0, s_vec_z = '0, s_scalar = '0;
    logic signed [31:0] s_origin_x = '0, s_origin_y = '0, s_origin_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_hit_valid;
    logic [1:0]         m_pick;
    logic signed [31:0] m_hit_t, m_hit_nx, m_hit_ny, m_hit_nz;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Bench copy of the plane table and the plane count register.
    logic signed [31:0] tbl_nx[NPLANES], tbl_ny[NPLANES], tbl_nz[NPLANES], tbl_d[NPLANES];
    logic [4:0]         active_cnt = '0;

    hit_t   expected_hits[$];
    bit     cur_typed = 1'b0;
    hit_t   cur_hit;
    int     accepted = 0;
    int     mismatches = 0;
    int     cycles = 0;
    row_t   rows[$];

    ray_convex_polyhedron_intersect #(.MAX_PLANES(NPLANES)) uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Q16.16 product floored toward minus infinity.
    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    // Q16.16 quotient truncated toward zero and saturated.
    function automatic longint qdivide(longint num, longint den);
        bit neg;
        longint unsigned un, ud, q, r, mag;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? -num : num;
        ud  = (den < 0) ? -den : den;
        q   = un / ud;
        r   = un % ud;
        if (q > 32768) mag = 64'h1_0000_0000;
        else mag = (q << 16) + ((r << 16) / ud);
        if (neg) begin
            if (mag > 64'h8000_0000) return longint'(rcpi_pkg::Q_MIN);
            return -longint'(mag);
        end
        if (mag > 64'h7FFF_FFFF) return longint'(rcpi_pkg::Q_MAX);
        return longint'(mag);
    endfunction

    // Clip one ray against the active planes and pick the reported hit.
    function automatic hit_t clip_ray(item_t it);
        hit_t   h;
        longint t_in, t_out, den, t, tmin;
        longint n0, n1, n2;
        logic signed [31:0] in_n[3], out_n[3];
        bit     got_in, got_out, ok;
        int     cnt;
        t_in = 0; t_out = 0; got_in = 0; got_out = 0;
        in_n = '{default: '0};
        out_n = '{default: '0};
        tmin = it.sc;
        cnt = (active_cnt > NPLANES) ? NPLANES : active_cnt;
        for (int i = 0; i < cnt; i++) begin
            if (got_in && got_out && !(t_in < t_out)) break;
            n0 = tbl_nx[i]; n1 = tbl_ny[i]; n2 = tbl_nz[i];
            den = qmul(n0, it.vx) + qmul(n1, it.vy) + qmul(n2, it.vz);
            if (den == 0) continue;
            t = qdivide(longint'(tbl_d[i]) -
                        (qmul(n0, it.ox) + qmul(n1, it.oy) + qmul(n2, it.oz)), den);
            if (den < 0) begin
                if (!got_in || t > t_in) begin
                    got_in = 1; t_in = t;
                    in_n = '{tbl_nx[i], tbl_ny[i], tbl_nz[i]};
                end
            end else if (!got_out || t < t_out) begin
                got_out = 1; t_out = t;
                out_n = '{tbl_nx[i], tbl_ny[i], tbl_nz[i]};
            end
        end
        ok = !(got_in && got_out) || t_in < t_out;
        h = '{hv: ok, pick: rcpi_pkg::PICK_NONE, t: '0, nx: '0, ny: '0, nz: '0};
        if (ok) begin
            if (got_in && t_in > tmin) begin
                h.pick = rcpi_pkg::PICK_ENTER; h.t = t_in[31:0];
                h.nx = in_n[0]; h.ny = in_n[1]; h.nz = in_n[2];
            end else if (!got_out || t_out > tmin) begin
                h.pick = rcpi_pkg::PICK_EXIT;
                h.t = got_out ? t_out[31:0] : rcpi_pkg::Q_MAX;
                h.nx = out_n[0]; h.ny = out_n[1]; h.nz = out_n[2];
            end
        end
        return h;
    endfunction

    // Input monitor: update the table on loads, queue the expected hit on rays.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            if (s_opcode == rcpi_pkg::OP_LOAD) begin
                tbl_nx[s_plane_slot] <= s_vec_x;
                tbl_ny[s_plane_slot] <= s_vec_y;
                tbl_nz[s_plane_slot] <= s_vec_z;
                tbl_d[s_plane_slot]  <= s_scalar;
            end else if (cur_typed) begin
                expected_hits.insert(expected_hits.size(), cur_hit);
            end else begin
                expected_hits.insert(expected_hits.size(), clip_ray('{s_opcode,
                    s_plane_slot, s_vec_x, s_vec_y, s_vec_z, s_scalar, s_origin_x,
                    s_origin_y, s_origin_z}));
            end
            accepted <= accepted + 1;
        end
    end

    // Output monitor: compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        hit_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_hits.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result transaction");
            end else begin
                e = expected_hits.pop_front();
                if (m_hit_valid !== e.hv || m_pick !== e.pick || m_hit_t !== e.t ||
                    m_hit_nx !== e.nx || m_hit_ny !== e.ny || m_hit_nz !== e.nz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: exp %0b %0d %h %h %h %h got %0b %0d %h %h %h %h",
                                 e.hv, e.pick, e.t, e.nx, e.ny, e.nz, m_hit_valid,
                                 m_pick, m_hit_t, m_hit_nx, m_hit_ny, m_hit_nz);
                end
            end
        end
    end

    // Receiver stall pattern: alternating stretches of always-ready and random stalls.
    always @(negedge aclk) begin
        if (cycles % 200 < 70) m_ready <= 1'b1;
        else if (cycles % 200 < 140) m_ready <= ($urandom_range(0, 3) != 0);
        else m_ready <= ($urandom_range(0, 4) == 0);
    end

    // Cycle limit guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Append one row to the stimulus table.
    function automatic void add_row(item_t it, bit typed, hit_t res);
        row_t row;
        row.it = it;
        row.typed = typed;
        row.res = res;
        rows.insert(rows.size(), row);
    endfunction

    // Drive one input transaction and wait until it is accepted.
    task automatic send(item_t it, bit typed, hit_t res);
        int target;
        target = accepted + 1;
        s_valid <= 1'b1;
        s_opcode <= it.op; s_plane_slot <= it.slot;
        s_vec_x <= it.vx; s_vec_y <= it.vy; s_vec_z <= it.vz; s_scalar <= it.sc;
        s_origin_x <= it.ox; s_origin_y <= it.oy; s_origin_z <= it.oz;
        cur_typed <= typed; cur_hit <= res;
        do @(negedge aclk); while (accepted < target);
    endtask

    // Sender bursts: occasionally drop valid for a random gap.
    int burst_left = 0;
    task automatic send_bursty(item_t it);
        hit_t none;
        none = '{default: '0};
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        send(it, 1'b0, none);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge aclk);
        repeat (DRAIN_WAIT) @(negedge aclk);
    endtask

    // Two-phase register write, done only while the block is idle.
    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 3'(4 * rcpi_pkg::REG_ACTIVE_PLANES)) active_cnt = val[4:0];
        @(negedge aclk);
    endtask

    function automatic item_t load_item(logic [3:0] slot, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z,
                                        logic signed [31:0] d);
        return '{rcpi_pkg::OP_LOAD, slot, x, y, z, d, $urandom, $urandom, $urandom};
    endfunction

    function automatic item_t ray_item(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z, logic signed [31:0] tmin,
                                       logic signed [31:0] ox, logic signed [31:0] oy,
                                       logic signed [31:0] oz);
        return '{rcpi_pkg::OP_RAY, 4'($urandom), x, y, z, tmin, ox, oy, oz};
    endfunction

    function automatic logic signed [31:0] srand(int lim);
        return 32'($signed($urandom_range(0, 2 * lim)) - lim);
    endfunction

    // Random polyhedron around the origin, one plane per slot.
    task automatic load_polyhedron();
        for (int k = 0; k < NPLANES; k++)
            send_bursty(load_item(4'(k), srand(32'h20000), srand(32'h20000),
                                  srand(32'h20000), $urandom_range(32'h8000, 32'h40000)));
    endtask

    localparam logic signed [31:0] ONE = 32'sh0001_0000;

    initial begin
        hit_t  none, h;
        item_t it;
        int    r;
        none = '{default: '0};

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed table: reset ray, cube planes, extremes and corner cases.
        h = '{hv: 1'b1, pick: rcpi_pkg::PICK_EXIT, t: rcpi_pkg::Q_MAX,
              nx: '0, ny: '0, nz: '0};
        add_row(ray_item(ONE, 0, 0, 0, 0, 0, 0), 1'b1, h);
        add_row(load_item(4'd0,  ONE, 0, 0, ONE), 1'b0, none);
        add_row(load_item(4'd1, -ONE, 0, 0, ONE), 1'b0, none);
        add_row(load_item(4'd2, 0,  ONE, 0, ONE), 1'b0, none);
        add_row(load_item(4'd3, 0, -ONE, 0, ONE), 1'b0, none);
        add_row(load_item(4'd4, 0, 0,  ONE, ONE), 1'b0, none);
        add_row(load_item(4'd5, 0, 0, -ONE, ONE), 1'b0, none);
        for (int k = 6; k < 15; k++)
            add_row(load_item(4'(k), srand(32'h20000), srand(32'h20000),
                              srand(32'h20000), -ONE), 1'b0, none);
        add_row(load_item(4'd15, rcpi_pkg::Q_MIN, rcpi_pkg::Q_MAX, rcpi_pkg::Q_MIN,
                          rcpi_pkg::Q_MAX), 1'b0, none);
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
        rows.delete();
        drain();
        reg_write(3'd4, 32'd3);     // unmapped register, ignored
        reg_write(3'(4 * rcpi_pkg::REG_ACTIVE_PLANES), 32'd6);

        // With the cube: exit hit, entry hit, t_min beyond both, parallel ray, miss.
        add_row(ray_item(ONE, 0, 0, 0, 0, 0, 0), 1'b0, none);
        add_row(ray_item(ONE, 0, 0, rcpi_pkg::Q_MIN, -2 * ONE, 0, 0), 1'b0, none);
        h = '{hv: 1'b1, pick: rcpi_pkg::PICK_NONE, t: '0, nx: '0, ny: '0, nz: '0};
        add_row(ray_item(ONE, 0, 0, rcpi_pkg::Q_MAX, 0, 0, 0), 1'b1, h);
        h = '{hv: 1'b1, pick: rcpi_pkg::PICK_EXIT, t: rcpi_pkg::Q_MAX,
              nx: '0, ny: '0, nz: '0};
        add_row(ray_item(0, 0, 0, 0, 0, 0, 0), 1'b1, h);
        // Diagonal ray starting outside the y slab leaves before it enters.
        add_row(ray_item(ONE, ONE, 0, 0, 0, 4 * ONE, 0), 1'b1, none);
        add_row(ray_item(rcpi_pkg::Q_MAX, rcpi_pkg::Q_MAX, rcpi_pkg::Q_MAX,
                         rcpi_pkg::Q_MAX, rcpi_pkg::Q_MAX, rcpi_pkg::Q_MAX,
                         rcpi_pkg::Q_MAX), 1'b0, none);
        add_row(ray_item(rcpi_pkg::Q_MIN, rcpi_pkg::Q_MIN, rcpi_pkg::Q_MIN,
                         rcpi_pkg::Q_MIN, rcpi_pkg::Q_MIN, rcpi_pkg::Q_MIN,
                         rcpi_pkg::Q_MIN), 1'b0, none);
        foreach (rows[i]) send(rows[i].it, rows[i].typed, rows[i].res);
        drain();
        reg_write(3'(4 * rcpi_pkg::REG_ACTIVE_PLANES), 32'd16);
        send(ray_item(rcpi_pkg::Q_MAX, rcpi_pkg::Q_MIN, ONE, 0, rcpi_pkg::Q_MIN,
                      rcpi_pkg::Q_MAX, 0), 1'b0, none);
        send(ray_item(ONE, ONE, ONE, -ONE, 0, 0, 0), 1'b0, none);
        drain();

        // Random phases: fresh polyhedron, new plane count, mostly well-formed rays.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: r = 31;
                1: r = 0;
                2: r = 16;
                3: r = 1;
                default: r = $urandom_range(0, 31);
            endcase
            reg_write(3'(4 * rcpi_pkg::REG_ACTIVE_PLANES), 32'(r));
            load_polyhedron();
            for (int n = 0; n < 34; n++) begin
                r = $urandom_range(0, 9);
                if (r < 8)
                    it = ray_item(srand(32'h20000), srand(32'h20000), srand(32'h20000),
                                  srand(32'h20000), srand(32'h8000), srand(32'h8000),
                                  srand(32'h8000));
                else if (r == 8)
                    it = ray_item($urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
                else
                    it = load_item(4'($urandom), $urandom, $urandom, $urandom, $urandom);
                send_bursty(it);
                if (ph == 2 && n == 17) begin
                    s_valid <= 1'b0;
                    while (expected_hits.size() != 0) @(negedge aclk);
                    @(negedge aclk);
                end
            end
            drain();
        end

        if (mismatches == 0 && expected_hits.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
